FILE: src/ogrc_pkg.sv
// ----------------------------------------------------------------------------
// ogrc_pkg
// shared types, codes and tables of the occupancy grid ray caster
// ----------------------------------------------------------------------------
package ogrc_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_RAY   = 2'd1,
    MODE_SWEEP = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_CORNER_X    = 3'd2,
    CFG_CORNER_Y    = 3'd3,
    CFG_CELLS_PER_M = 3'd4,
    CFG_THRESHOLD   = 3'd5,
    CFG_MARCH_STEP  = 3'd6,
    CFG_SWEEP_INC   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RAY_INIT,
    ST_CORDIC,
    ST_CONV_MUL,
    ST_CONV_CELL,
    ST_INDEX,
    ST_READ,
    ST_TEST,
    ST_STEP,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_RAY_DONE,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE,
    OP_RAY_INIT,
    OP_CORDIC,
    OP_CONV_MUL,
    OP_CONV_CELL,
    OP_INDEX,
    OP_READ,
    OP_STEP,
    OP_SQUARE,
    OP_SUM,
    OP_SQRT,
    OP_RAY_DONE
  } op_t;

  typedef struct packed {
    logic cordic_last;
    logic in_map;
    logic blocked;
    logic sqrt_last;
    logic sweep_last;
  } stat_t;

  localparam logic [15:0] CORDIC_GAIN = 16'd39797;
  localparam logic [15:0] SWEEP_START = 16'd49152;
  localparam logic [17:0] SWEEP_SPAN  = 18'd32768;

  // arctangent of 2^-i in binary angle units
  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    logic [13:0] v;
    unique case (i)
      4'd0:  v = 14'd8192;
      4'd1:  v = 14'd4836;
      4'd2:  v = 14'd2555;
      4'd3:  v = 14'd1297;
      4'd4:  v = 14'd651;
      4'd5:  v = 14'd326;
      4'd6:  v = 14'd163;
      4'd7:  v = 14'd81;
      4'd8:  v = 14'd41;
      4'd9:  v = 14'd20;
      4'd10: v = 14'd10;
      4'd11: v = 14'd5;
      4'd12: v = 14'd3;
      4'd13: v = 14'd1;
      4'd14: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/ogrc_ctrl.sv
// ----------------------------------------------------------------------------
// ogrc_ctrl
// sequencer: cell writes, ray setup, march loop, range and sweep bookkeeping
// ----------------------------------------------------------------------------
module ogrc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_mode,
  input  ogrc_pkg::stat_t stat,
  output ogrc_pkg::op_t   op,
  output logic            busy,
  output logic            out_valid
);
  import ogrc_pkg::*;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          if (mode_t'(in_mode) == MODE_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (mode_t'(in_mode) == MODE_RAY || mode_t'(in_mode) == MODE_SWEEP) begin
            state_nxt = ST_RAY_INIT;
          end
        end
      end
      ST_WRITE: begin
        op        = OP_WRITE;
        state_nxt = ST_IDLE;
      end
      ST_RAY_INIT: begin
        op        = OP_RAY_INIT;
        first_nxt = 1'b1;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        op = OP_CORDIC;
        if (stat.cordic_last) state_nxt = ST_CONV_MUL;
      end
      ST_CONV_MUL: begin
        op        = OP_CONV_MUL;
        state_nxt = ST_CONV_CELL;
      end
      ST_CONV_CELL: begin
        op        = OP_CONV_CELL;
        state_nxt = ST_INDEX;
      end
      ST_INDEX: begin
        op = OP_INDEX;
        if (!stat.in_map) begin
          state_nxt = ST_RAY_DONE;
        end else if (first_r) begin
          first_nxt = 1'b0;
          state_nxt = ST_STEP;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        op        = OP_READ;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        state_nxt = stat.blocked ? ST_SQUARE : ST_STEP;
      end
      ST_STEP: begin
        op        = OP_STEP;
        state_nxt = ST_CONV_MUL;
      end
      ST_SQUARE: begin
        op        = OP_SQUARE;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        op        = OP_SUM;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        op = OP_SQRT;
        if (stat.sqrt_last) state_nxt = ST_RAY_DONE;
      end
      ST_RAY_DONE: begin
        op        = OP_RAY_DONE;
        state_nxt = stat.sweep_last ? ST_OUT : ST_RAY_INIT;
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  a_write_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && mode_t'(in_mode) == MODE_WRITE) |=> state_r == ST_WRITE)
    else $error("cell write not sequenced");

  a_test_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TEST |-> $past(state_r) == ST_READ)
    else $error("cell test without a read");

  a_sweep_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RAY_DONE && !stat.sweep_last) |=> state_r == ST_RAY_INIT)
    else $error("sweep ended early");

endmodule

FILE: src/ogrc_dp.sv
// ----------------------------------------------------------------------------
// ogrc_dp
// datapath: config registers, grid memory, cordic, cell conversion, isqrt
// ----------------------------------------------------------------------------
module ogrc_dp #(
  parameter int GRID_CELLS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ogrc_pkg::op_t      op,
  output ogrc_pkg::stat_t    stat,
  input  logic               cfg_we,
  input  ogrc_pkg::cfg_idx_t cfg_sel,
  input  logic [23:0]        cfg_data,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_cell_index,
  input  logic [7:0]         in_cell_value,
  input  logic [23:0]        in_ray_origin_x,
  input  logic [23:0]        in_ray_origin_y,
  input  logic [15:0]        in_heading,
  output logic [23:0]        out_range_to_hit,
  output logic               out_hit,
  output logic [15:0]        out_best_heading
);
  import ogrc_pkg::*;

  localparam int AW = $clog2(GRID_CELLS);

  // configuration
  logic [8:0]         width_r, height_r;
  logic signed [23:0] corner_x_r, corner_y_r;
  logic [15:0]        cpm_r;
  logic signed [7:0]  thr_r;
  logic [11:0]        step_r;
  logic [14:0]        inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 9'd256;
      height_r   <= 9'd256;
      corner_x_r <= '0;
      corner_y_r <= '0;
      cpm_r      <= 16'd5120;
      thr_r      <= 8'sd50;
      step_r     <= 12'd205;
      inc_r      <= 15'd182;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        CFG_GRID_WIDTH:  width_r    <= cfg_data[8:0];
        CFG_GRID_HEIGHT: height_r   <= cfg_data[8:0];
        CFG_CORNER_X:    corner_x_r <= $signed(cfg_data);
        CFG_CORNER_Y:    corner_y_r <= $signed(cfg_data);
        CFG_CELLS_PER_M: cpm_r      <= cfg_data[15:0];
        CFG_THRESHOLD:   thr_r      <= $signed(cfg_data[7:0]);
        CFG_MARCH_STEP:  step_r     <= cfg_data[11:0];
        CFG_SWEEP_INC:   inc_r      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [15:0] cpm_eff;
  logic [11:0] step_eff;
  logic [14:0] inc_eff;
  assign cpm_eff  = (cpm_r == '0) ? 16'd1 : cpm_r;
  assign step_eff = (step_r == '0) ? 12'd1 : step_r;
  assign inc_eff  = (inc_r == '0) ? 15'd1 : inc_r;

  // item and ray registers
  mode_t              mode_r;
  logic [15:0]        cidx_r, hd_r, h_r;
  logic [7:0]         cval_r;
  logic signed [23:0] ox_r, oy_r;
  logic [16:0]        off_r;
  logic signed [32:0] rx_r, ry_r;
  logic signed [23:0] cx_r, cy_r;
  logic signed [16:0] ang_r;
  logic               flip_r;
  logic signed [39:0] ex_r, ey_r;
  logic [4:0]         cnt_r;
  logic               psx_r, psy_r;
  logic [39:0]        lox_r, loy_r;
  logic [32:0]        hix_r, hiy_r;
  logic               in_map_r;
  logic [8:0]         gx_r, gy_r;
  logic [17:0]        idx_r;
  logic [7:0]         rd_r;
  logic               oob_r;
  logic               sat_r;
  logic [59:0]        sqx_r, sqy_r;
  logic [62:0]        key_r, rem_r, res_r, bit_r;
  logic               cur_hit_r;
  logic               best_hit_r;
  logic [62:0]        best_key_r;
  logic [23:0]        best_range_r;
  logic [15:0]        best_hd_r;

  // ray setup: heading fold and start vector
  logic [15:0]        h_nxt;
  logic signed [16:0] a0, a_fold;
  logic               flip0;
  logic [35:0]        x0_prod;

  always_comb begin
    h_nxt = (mode_r == MODE_RAY) ? hd_r : hd_r + SWEEP_START + off_r[15:0];
    a0    = $signed({h_nxt[15], h_nxt});
    flip0 = 1'b0;
    a_fold = a0;
    if (a0 >= 17'sd16384) begin
      a_fold = a0 - 17'sd32768;
      flip0  = 1'b1;
    end else if (a0 < -17'sd16384) begin
      a_fold = a0 + 17'sd32768;
      flip0  = 1'b1;
    end
    x0_prod = 36'({step_eff, 8'h00}) * 36'(CORDIC_GAIN);
  end

  // start point relative to the map corner, meters Q12.12
  logic signed [24:0] rel_x, rel_y;
  assign rel_x = $signed({ox_r[23], ox_r}) - $signed({corner_x_r[23], corner_x_r});
  assign rel_y = $signed({oy_r[23], oy_r}) - $signed({corner_y_r[23], corner_y_r});

  // cordic micro-rotation
  logic signed [23:0] xsh, ysh;
  logic signed [16:0] atan_s;
  assign xsh    = cx_r >>> cnt_r[3:0];
  assign ysh    = cy_r >>> cnt_r[3:0];
  assign atan_s = $signed({3'b000, atan_lut(cnt_r[3:0])});

  // step vector and position
  logic signed [23:0] dx, dy;
  logic signed [40:0] px, py;
  logic [40:0]        magx, magy;
  assign dx   = flip_r ? -cx_r : cx_r;
  assign dy   = flip_r ? -cy_r : cy_r;
  assign px   = {{8{rx_r[32]}}, rx_r} + {ex_r[39], ex_r};
  assign py   = {{8{ry_r[32]}}, ry_r} + {ey_r[39], ey_r};
  assign magx = px[40] ? 41'(-px) : 41'(px);
  assign magy = py[40] ? 41'(-py) : 41'(py);

  // cell from partial products
  logic [56:0] fullx, fully;
  logic [28:0] cellx, celly;
  logic        inx, iny;
  assign fullx = {hix_r, 24'h000000} + 57'(lox_r);
  assign fully = {hiy_r, 24'h000000} + 57'(loy_r);
  assign cellx = fullx[56:28];
  assign celly = fully[56:28];
  assign inx   = (!psx_r || cellx == '0) && (cellx < 29'(width_r));
  assign iny   = (!psy_r || celly == '0) && (celly < 29'(height_r));

  // range terms
  logic [39:0] aex, aey;
  logic [37:0] ax, ay;
  logic [62:0] key_nxt, trial;
  logic [23:0] cur_range;
  logic        better;
  assign aex     = ex_r[39] ? 40'(-ex_r) : 40'(ex_r);
  assign aey     = ey_r[39] ? 40'(-ey_r) : 40'(ey_r);
  assign ax      = aex[39:2];
  assign ay      = aey[39:2];
  assign key_nxt = sat_r ? (63'd1 << 62) : 63'(sqx_r) + 63'(sqy_r);
  assign trial   = res_r + bit_r;
  assign cur_range = !cur_hit_r ? 24'd0 :
                     (res_r[62:30] != '0) ? 24'hFFFFFF : res_r[29:6];
  assign better  = (off_r == '0) ||
                   (best_hit_r && (!cur_hit_r || key_r > best_key_r));

  logic signed [7:0] cell_val;
  assign cell_val = oob_r ? 8'sd0 : $signed(rd_r);

  assign stat.cordic_last = (cnt_r[3:0] == 4'd15);
  assign stat.in_map      = in_map_r;
  assign stat.blocked     = (cell_val >= thr_r);
  assign stat.sqrt_last   = (cnt_r == 5'd31);
  assign stat.sweep_last  = (mode_r == MODE_RAY) ||
                            (18'(off_r) + 18'(inc_eff) > SWEEP_SPAN);

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        mode_r <= mode_t'(in_mode);
        cidx_r <= in_cell_index;
        cval_r <= in_cell_value;
        ox_r   <= $signed(in_ray_origin_x);
        oy_r   <= $signed(in_ray_origin_y);
        hd_r   <= in_heading;
        off_r  <= '0;
      end
      OP_RAY_INIT: begin
        h_r       <= h_nxt;
        rx_r      <= {rel_x, 8'h00};
        ry_r      <= {rel_y, 8'h00};
        cx_r      <= $signed({4'h0, x0_prod[35:16]});
        cy_r      <= '0;
        ang_r     <= a_fold;
        flip_r    <= flip0;
        ex_r      <= '0;
        ey_r      <= '0;
        cnt_r     <= '0;
        cur_hit_r <= 1'b0;
        key_r     <= '0;
        res_r     <= '0;
      end
      OP_CORDIC: begin
        if (!ang_r[16]) begin
          cx_r  <= cx_r - ysh;
          cy_r  <= cy_r + xsh;
          ang_r <= ang_r - atan_s;
        end else begin
          cx_r  <= cx_r + ysh;
          cy_r  <= cy_r - xsh;
          ang_r <= ang_r + atan_s;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      OP_CONV_MUL: begin
        psx_r <= px[40];
        psy_r <= py[40];
        lox_r <= 40'(magx[23:0]) * 40'(cpm_eff);
        loy_r <= 40'(magy[23:0]) * 40'(cpm_eff);
        hix_r <= 33'(magx[40:24]) * 33'(cpm_eff);
        hiy_r <= 33'(magy[40:24]) * 33'(cpm_eff);
      end
      OP_CONV_CELL: begin
        in_map_r <= inx && iny;
        gx_r     <= cellx[8:0];
        gy_r     <= celly[8:0];
      end
      OP_INDEX: begin
        idx_r <= 18'(gy_r) * 18'(width_r) + 18'(gx_r);
      end
      OP_READ: begin
        oob_r <= (32'(idx_r) >= 32'(GRID_CELLS));
      end
      OP_STEP: begin
        ex_r <= ex_r + {{16{dx[23]}}, dx};
        ey_r <= ey_r + {{16{dy[23]}}, dy};
      end
      OP_SQUARE: begin
        cur_hit_r <= 1'b1;
        sat_r     <= (ax[37:30] != '0) || (ay[37:30] != '0);
        sqx_r     <= 60'(ax[29:0]) * 60'(ax[29:0]);
        sqy_r     <= 60'(ay[29:0]) * 60'(ay[29:0]);
      end
      OP_SUM: begin
        key_r <= key_nxt;
        rem_r <= key_nxt;
        res_r <= '0;
        bit_r <= 63'd1 << 62;
        cnt_r <= '0;
      end
      OP_SQRT: begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
      end
      OP_RAY_DONE: begin
        if (better) begin
          best_hit_r   <= cur_hit_r;
          best_key_r   <= key_r;
          best_range_r <= cur_range;
          best_hd_r    <= h_r;
        end
        off_r <= off_r + 17'(inc_eff);
      end
      default: ;
    endcase
  end

  // occupancy grid
  logic [7:0] grid_mem [GRID_CELLS];

  always_ff @(posedge clk) begin
    if (op == OP_WRITE && 32'(cidx_r) < 32'(GRID_CELLS)) begin
      grid_mem[AW'(cidx_r)] <= cval_r;
    end
    if (op == OP_READ) begin
      rd_r <= grid_mem[AW'(idx_r)];
    end
  end

  assign out_range_to_hit = best_range_r;
  assign out_hit          = best_hit_r;
  assign out_best_heading = best_hd_r;

endmodule

FILE: src/occupancy_grid_ray_caster_top.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_caster_top
// occupancy grid store with single-ray and sweep ray marching
// ----------------------------------------------------------------------------
// One item is taken when start is high and busy is low; busy stays high until
// the item is done. Mode 0 writes one cell and gives no result.
// Mode 1 casts one ray; mode 2 casts floor(32768 / sweep_increment) + 1 rays
// and keeps the farthest. Each ray has a setup step, the cordic rotation,
// the check that the start cell lies in the map, march steps through the
// single-port grid memory, squaring and the bit-serial square root on a
// hit, and a final step to rank it.
// The result shows on out_* with out_valid high for exactly one cycle, in the
// cycle after the last ray is ranked; the receiver cannot stall it, so it must be taken then.
// Modes 0 and 3 give no result. Config writes are taken every cycle
// (cfg_ready is tied high) and must only happen while busy is low.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_caster_top #(
  parameter int GRID_CELLS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_cell_index,
  input  logic [7:0]  in_cell_value,
  input  logic [23:0] in_ray_origin_x,
  input  logic [23:0] in_ray_origin_y,
  input  logic [15:0] in_heading,
  // result channel
  output logic        out_valid,
  output logic [23:0] out_range_to_hit,
  output logic        out_hit,
  output logic [15:0] out_best_heading,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import ogrc_pkg::*;

  op_t   op;
  stat_t stat;
  logic  accept;

  // registers are plain flops, always writable
  assign cfg_ready = 1'b1;
  // item handshake
  assign accept    = start && !busy;

  // sequencer
  ogrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .in_mode   (in_mode),
    .stat      (stat),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // grid, cordic, cell math and range unit
  ogrc_dp #(
    .GRID_CELLS (GRID_CELLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_sel          (cfg_idx_t'(cfg_index)),
    .cfg_data         (cfg_data),
    .in_mode          (in_mode),
    .in_cell_index    (in_cell_index),
    .in_cell_value    (in_cell_value),
    .in_ray_origin_x  (in_ray_origin_x),
    .in_ray_origin_y  (in_ray_origin_y),
    .in_heading       (in_heading),
    .out_range_to_hit (out_range_to_hit),
    .out_hit          (out_hit),
    .out_best_heading (out_best_heading)
  );

endmodule
